/* hw/rtl/ramped_stepper_launch_sequencer_top_defines.svh */
// Assertion macros for the ramped stepper launch sequencer.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef RAMPED_STEPPER_LAUNCH_SEQUENCER_TOP_DEFINES_SVH
`define RAMPED_STEPPER_LAUNCH_SEQUENCER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RSLS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rsls: check failed");
`define RSLS_NEVER(lbl, clk, rst_n, cond) \
	`RSLS_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define RSLS_ASSERT(lbl, clk, rst_n, prop)
`define RSLS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/rsls_pkg.sv */
// Shared types and constants of the ramped stepper launch sequencer.
// Used by rsls_ctrl, rsls_dp and the top level; depends on nothing.
package rsls_pkg;

	localparam int STEP_BITS_DEF  = 20;
	localparam int DELAY_BITS_DEF = 12;
	localparam int MOTOR_COUNT    = 4;
	localparam int MOTOR_LIM      = (MOTOR_COUNT < 4) ? MOTOR_COUNT : 4;
	localparam int CFG_IDX_BITS   = 3;

	localparam int RST_STEPS = 10000;
	localparam int RST_RAMP  = 2000;
	localparam int RST_SLOW  = 600;
	localparam int RST_FAST  = 50;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_LAUNCH = 2'd1;
	localparam logic [1:0] CMD_RESET  = 2'd2;
	localparam logic [1:0] CMD_JOG    = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_STEPS_ONE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEPS_TWO   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEPS_THREE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEPS_FOUR  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RAMP        = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOW        = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_FAST        = 3'd6;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] motor_sel;
		logic       jog_forward;
	} item_t;

	typedef struct packed {
		logic [3:0] step_lines;
		logic [3:0] dir_lines;
		logic       moving;
		logic       is_launched;
		logic       move_done;
	} result_t;

	typedef struct packed {
		logic load_in;
		logic decide;
		logic prep;
		logic mul;
		logic div_step;
		logic fix;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic need_calc;
		logic ramp_on;
	} dp_stat_t;

endpackage

/* hw/rtl/rsls_ctrl.sv */
// Controller of the ramped stepper launch sequencer: request handshake,
// sequencing of decide, half period calculation and result load. Uses rsls_pkg.
module rsls_ctrl #(
	parameter int DELAY_BITS = rsls_pkg::DELAY_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	output logic               res_valid,
	input  logic               res_stall,
	input  rsls_pkg::dp_stat_t stat,
	output rsls_pkg::dp_cmd_t  cmd
);
	import rsls_pkg::*;

	localparam int CNT_W = $clog2(DELAY_BITS);

	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_PREP, S_MUL, S_DIV, S_FIX, S_OUT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               res_valid_q;
	logic               out_free;

	assign out_free   = !res_valid_q || !res_stall;
	assign item_stall = (state_q != S_IDLE);
	assign res_valid  = res_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load_in  = item_valid;
			S_DECIDE: cmd.decide   = 1'b1;
			S_PREP:   cmd.prep     = 1'b1;
			S_MUL:    cmd.mul      = 1'b1;
			S_DIV:    cmd.div_step = 1'b1;
			S_FIX:    cmd.fix      = 1'b1;
			S_OUT:    cmd.out_load = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= stat.need_calc ? S_PREP : S_OUT;
				end
				S_PREP: begin
					state_q <= stat.ramp_on ? S_MUL : S_FIX;
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DELAY_BITS - 1)) state_q <= S_FIX;
				end
				S_FIX: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/rsls_dp.sv */
// Datapath of the ramped stepper launch sequencer: registers, motor state,
// half period multiply and restoring divide, result register. Uses rsls_pkg.
module rsls_dp #(
	parameter int STEP_BITS  = rsls_pkg::STEP_BITS_DEF,
	parameter int DELAY_BITS = rsls_pkg::DELAY_BITS_DEF,
	parameter int CFG_W      = (STEP_BITS > DELAY_BITS) ? STEP_BITS : DELAY_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rsls_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_W-1:0]                    cfg_data,
	input  rsls_pkg::item_t                     item,
	input  rsls_pkg::dp_cmd_t                   cmd,
	output rsls_pkg::dp_stat_t                  stat,
	output rsls_pkg::result_t                   res
);
	import rsls_pkg::*;

	localparam int SB = STEP_BITS;
	localparam int DB = DELAY_BITS;
	localparam int PW = STEP_BITS + DELAY_BITS;

	logic [3:0][SB-1:0] steps_q;
	logic [SB-1:0]      ramp_q;
	logic [DB-1:0]      slow_q;
	logic [DB-1:0]      fast_q;

	logic [1:0]         cmd_q;
	logic [1:0]         sel_q;
	logic               fwd_q;

	logic               launched_q, busy_q, single_q, mdir_q, pulse_q, done_q;
	logic [1:0]         active_q;
	logic [SB-1:0]      step_idx_q;
	logic [DB-1:0]      hpl_q;
	logic [DB-1:0]      cur_hp_q;
	logic [3:0]         dirl_q;

	logic               nx_launched, nx_busy, nx_single, nx_mdir, nx_pulse, nx_done;
	logic [1:0]         nx_active;
	logic [SB-1:0]      nx_idx;
	logic [DB-1:0]      nx_hpl;
	logic [3:0]         nx_dirl;
	logic               need_calc, go_begin, go_finish, cmd_ok;
	logic [1:0]         k_sel;

	logic [SB-1:0]      n_act;
	logic [SB-1:0]      idx1;
	logic [2:0]         search_from;
	logic               found;
	logic [1:0]         k_found;

	logic [SB-1:0]      half_n;
	logic [SB-1:0]      n_less_ramp;
	logic               accel, decel;
	logic [SB-1:0]      m_n;
	logic [DB-1:0]      absd_n;
	logic               neg_n;
	logic [DB-1:0]      base_n;

	logic [SB-1:0]      m_q;
	logic [DB-1:0]      absd_q;
	logic               neg_q;
	logic [DB-1:0]      base_q;
	logic               ramp_on_q;

	logic [PW-1:0]      prod;
	logic [SB-1:0]      rem_q;
	logic [DB-1:0]      quo_q;
	logic [SB:0]        trial;
	logic               trial_ge;

	logic [DB-1:0]      q_use;
	logic [DB:0]        dval;
	logic [DB-1:0]      dfin;

	result_t            res_q;

	// decide
	assign n_act       = steps_q[active_q];
	assign idx1        = step_idx_q + SB'(1);
	assign search_from = (cmd_q == CMD_TICK) ? ({1'b0, active_q} + 3'd1) : 3'd0;
	assign cmd_ok      = ((cmd_q == CMD_LAUNCH) && !launched_q)
			|| ((cmd_q == CMD_RESET) && launched_q)
			|| ((cmd_q == CMD_JOG) && ({2'b00, sel_q} < 4'(MOTOR_COUNT)));

	always_comb begin
		found   = 1'b0;
		k_found = 2'd0;
		for (int j = 3; j >= 0; j--) begin
			if (3'(j) >= search_from && j < MOTOR_LIM && steps_q[j] != '0) begin
				found   = 1'b1;
				k_found = 2'(j);
			end
		end
	end

	always_comb begin
		nx_launched = launched_q;
		nx_busy     = busy_q;
		nx_single   = single_q;
		nx_active   = active_q;
		nx_mdir     = mdir_q;
		nx_idx      = step_idx_q;
		nx_hpl      = hpl_q;
		nx_pulse    = pulse_q;
		nx_dirl     = dirl_q;
		nx_done     = 1'b0;
		need_calc   = 1'b0;
		go_begin    = 1'b0;
		go_finish   = 1'b0;
		k_sel       = k_found;
		if (cmd_q == CMD_TICK) begin
			if (busy_q) begin
				if (hpl_q > DB'(1)) begin
					nx_hpl = hpl_q - DB'(1);
				end else if (pulse_q) begin
					nx_pulse = 1'b0;
					nx_hpl   = cur_hp_q;
				end else begin
					nx_idx = idx1;
					if (idx1 != '0 && idx1 < n_act) begin
						need_calc = 1'b1;
					end else if (single_q) begin
						go_finish = 1'b1;
					end else if (found) begin
						go_begin = 1'b1;
					end else begin
						go_finish = 1'b1;
					end
				end
			end
		end else if (!busy_q && cmd_ok) begin
			nx_busy   = 1'b1;
			nx_single = (cmd_q == CMD_JOG);
			nx_mdir   = (cmd_q == CMD_JOG) ? fwd_q : (cmd_q == CMD_LAUNCH);
			if (cmd_q == CMD_JOG) begin
				k_sel = sel_q;
				if (steps_q[sel_q] != '0) go_begin = 1'b1;
				else go_finish = 1'b1;
			end else if (found) begin
				go_begin = 1'b1;
			end else begin
				go_finish = 1'b1;
			end
		end
		if (go_begin) begin
			nx_active        = k_sel;
			nx_dirl[k_sel]   = nx_mdir;
			nx_idx           = '0;
			need_calc        = 1'b1;
		end
		if (go_finish) begin
			nx_busy  = 1'b0;
			nx_pulse = 1'b0;
			nx_hpl   = '0;
			if (!nx_single) nx_launched = nx_mdir;
			nx_done  = 1'b1;
		end
	end

	// half period: ramp phase and operands
	assign half_n      = n_act >> 1;
	assign n_less_ramp = n_act - ramp_q;
	assign accel       = (step_idx_q < ramp_q) && (step_idx_q < half_n);
	assign decel       = !accel && (ramp_q != '0) && (ramp_q <= n_act)
			&& (step_idx_q > n_less_ramp) && (step_idx_q > half_n);
	assign m_n         = accel ? step_idx_q : (step_idx_q - n_less_ramp);
	assign absd_n      = (slow_q >= fast_q) ? (slow_q - fast_q) : (fast_q - slow_q);
	assign neg_n       = accel ? (fast_q < slow_q) : (slow_q < fast_q);
	assign base_n      = accel ? slow_q : fast_q;

	assign stat.need_calc = need_calc;
	assign stat.ramp_on   = accel || decel;

	// multiply, then one quotient bit per cycle
	assign prod     = PW'(m_q) * PW'(absd_q);
	assign trial    = {rem_q, quo_q[DB-1]};
	assign trial_ge = (trial >= {1'b0, ramp_q});

	assign q_use = ramp_on_q ? quo_q : '0;
	assign dval  = neg_q ? ({1'b0, base_q} - {1'b0, q_use}) : ({1'b0, base_q} + {1'b0, q_use});
	assign dfin  = (dval[DB] || dval[DB-1:0] == '0) ? DB'(1) : dval[DB-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= item.cmd;
			sel_q <= item.motor_sel;
			fwd_q <= item.jog_forward;
		end
		if (cmd.prep) begin
			m_q       <= m_n;
			absd_q    <= absd_n;
			neg_q     <= neg_n;
			base_q    <= base_n;
			ramp_on_q <= accel || decel;
		end
		if (cmd.mul) begin
			quo_q <= prod[DB-1:0];
			rem_q <= prod[PW-1:DB];
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DB-2:0], trial_ge};
			rem_q <= trial_ge ? SB'(trial - {1'b0, ramp_q}) : trial[SB-1:0];
		end
		if (cmd.out_load) begin
			res_q.step_lines  <= (busy_q && pulse_q) ? (4'd1 << active_q) : 4'd0;
			res_q.dir_lines   <= dirl_q;
			res_q.moving      <= busy_q;
			res_q.is_launched <= launched_q;
			res_q.move_done   <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q    <= {4{SB'(RST_STEPS)}};
			ramp_q     <= SB'(RST_RAMP);
			slow_q     <= DB'(RST_SLOW);
			fast_q     <= DB'(RST_FAST);
			launched_q <= 1'b0;
			busy_q     <= 1'b0;
			single_q   <= 1'b0;
			active_q   <= 2'd0;
			mdir_q     <= 1'b0;
			step_idx_q <= '0;
			hpl_q      <= '0;
			cur_hp_q   <= '0;
			pulse_q    <= 1'b0;
			dirl_q     <= 4'd0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STEPS_ONE:   steps_q[0] <= cfg_data[SB-1:0];
					REG_STEPS_TWO:   steps_q[1] <= cfg_data[SB-1:0];
					REG_STEPS_THREE: steps_q[2] <= cfg_data[SB-1:0];
					REG_STEPS_FOUR:  steps_q[3] <= cfg_data[SB-1:0];
					REG_RAMP:        ramp_q     <= cfg_data[SB-1:0];
					REG_SLOW:        slow_q     <= cfg_data[DB-1:0];
					REG_FAST:        fast_q     <= cfg_data[DB-1:0];
					default: ;
				endcase
			end
			if (cmd.decide) begin
				launched_q <= nx_launched;
				busy_q     <= nx_busy;
				single_q   <= nx_single;
				active_q   <= nx_active;
				mdir_q     <= nx_mdir;
				step_idx_q <= nx_idx;
				hpl_q      <= nx_hpl;
				pulse_q    <= nx_pulse;
				dirl_q     <= nx_dirl;
				done_q     <= nx_done;
			end else if (cmd.fix) begin
				cur_hp_q <= dfin;
				hpl_q    <= dfin;
				pulse_q  <= 1'b1;
			end
		end
	end

	assign res = res_q;

endmodule

/* hw/rtl/ramped_stepper_launch_sequencer_top.sv */
// Ramped stepper launch sequencer: four motor step/direction generator.
// One request at a time. A tick that starts no step goes from decide
// straight to the result load. A request that starts a step also passes
// prep and fix, and inside a ramp a multiply and the restoring divider
// that makes one quotient bit per cycle. Reset: not launched, idle, no
// result valid, registers at 10000/2000/600/50.
`include "ramped_stepper_launch_sequencer_top_defines.svh"
module ramped_stepper_launch_sequencer_top #(
	parameter int STEP_BITS  = rsls_pkg::STEP_BITS_DEF,
	parameter int DELAY_BITS = rsls_pkg::DELAY_BITS_DEF,
	parameter int CFG_W      = (STEP_BITS > DELAY_BITS) ? STEP_BITS : DELAY_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  rsls_pkg::item_t                   item,
	output logic                              res_valid,
	input  logic                              res_stall,
	output rsls_pkg::result_t                 res,
	input  logic                              cfg_we,
	input  logic [rsls_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data
);
	import rsls_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	rsls_ctrl #(
		.DELAY_BITS (DELAY_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.stat       (dp_stat),
		.cmd        (dp_cmd)
	);

	rsls_dp #(
		.STEP_BITS  (STEP_BITS),
		.DELAY_BITS (DELAY_BITS),
		.CFG_W      (CFG_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.res       (res)
	);

	`RSLS_ASSERT(a_accept_holds_off, clk, arst_n, item_valid && !item_stall |=> item_stall)
	`RSLS_ASSERT(a_one_step_line, clk, arst_n, res_valid |-> $onehot0(res.step_lines))
	`RSLS_NEVER(a_done_while_moving, clk, arst_n, res_valid && res.move_done && res.moving)
	`RSLS_ASSERT(a_step_needs_move, clk, arst_n, res_valid && (res.step_lines != 4'd0) |-> res.moving)

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for ramped_stepper_launch_sequencer_top: directed table,
// then randomized phases checked against an in-bench motion predictor.
// Depends on rsls_pkg and the sequencer RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rsls_pkg::*;

	localparam int SW = STEP_BITS_DEF;
	localparam int DW = DELAY_BITS_DEF;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 30;
	localparam int TAIL_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int EDGE_TICKS = 40;

	typedef struct packed {
		item_t   req;
		bit      typed;
		result_t want;
		bit      settle;
	} row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    item_valid;
	logic                    item_stall;
	item_t                   item;
	logic                    res_valid;
	logic                    res_stall;
	result_t                 res;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [SW-1:0]           cfg_data;

	// predicted registers and motion state
	logic [SW-1:0] steps_p [4];
	logic [SW-1:0] ramp_p;
	logic [DW-1:0] slow_p, fast_p;
	logic          launched_p, busy_p, single_p, mdir_p, pulse_p, done_p;
	logic [1:0]    active_p;
	logic [SW-1:0] step_idx_p;
	logic [DW-1:0] hp_left_p, hp_cur_p;
	logic [3:0]    dirs_p;

	result_t lines_due [$];
	result_t lines_want;
	row_t    plan [$];
	int      err_count = 0;
	int      res_count = 0;
	int      cycle_count = 0;
	int      burst_left = 0;
	bit      hold_off_req = 1'b0;

	ramped_stepper_launch_sequencer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic note_error(input string msg);
		$display("ERROR cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	function automatic logic [DW-1:0] half_period_at(logic [SW-1:0] i, logic [SW-1:0] n);
		longint r, s, t, ii, nn, d;
		logic [DW-1:0] hp;
		r = ramp_p;
		s = slow_p;
		t = fast_p;
		ii = i;
		nn = n;
		d = t;
		if (ii < r && ii < nn / 2)
			d = s + ii * (t - s) / r;
		else if (r != 0 && r <= nn && ii > nn - r && ii > nn / 2)
			d = t + (ii - (nn - r)) * (s - t) / r;
		if (d <= 0)
			d = 1;
		hp = d[DW-1:0];
		return hp;
	endfunction

	function automatic int first_motor_from(int k);
		for (int m = k; m < MOTOR_LIM; m++)
			if (steps_p[m] != 0)
				return m;
		return -1;
	endfunction

	task automatic launch_pulse();
		hp_cur_p = half_period_at(step_idx_p, steps_p[active_p]);
		hp_left_p = hp_cur_p;
		pulse_p = 1'b1;
	endtask

	task automatic enter_motor(input int k);
		active_p = k[1:0];
		dirs_p[k[1:0]] = mdir_p;
		step_idx_p = '0;
		launch_pulse();
	endtask

	task automatic finish_move();
		busy_p = 1'b0;
		pulse_p = 1'b0;
		hp_left_p = '0;
		if (!single_p)
			launched_p = mdir_p;
		done_p = 1'b1;
	endtask

	task automatic open_move(input int first, input bit single, input bit fwd);
		int k;
		single_p = single;
		mdir_p = fwd;
		busy_p = 1'b1;
		if (single)
			k = (steps_p[first] != 0) ? first : -1;
		else
			k = first_motor_from(first);
		if (k < 0)
			finish_move();
		else
			enter_motor(k);
	endtask

	task automatic step_motion(input item_t req, output result_t lines);
		int k;
		done_p = 1'b0;
		if (req.cmd == CMD_TICK) begin
			if (busy_p) begin
				if (hp_left_p > 1) begin
					hp_left_p = hp_left_p - 1'b1;
				end else if (pulse_p) begin
					pulse_p = 1'b0;
					hp_left_p = hp_cur_p;
				end else begin
					step_idx_p = step_idx_p + 1'b1;
					if (step_idx_p != 0 && step_idx_p < steps_p[active_p]) begin
						launch_pulse();
					end else if (single_p) begin
						finish_move();
					end else begin
						k = first_motor_from(int'(active_p) + 1);
						if (k < 0)
							finish_move();
						else
							enter_motor(k);
					end
				end
			end
		end else if (!busy_p) begin
			if (req.cmd == CMD_LAUNCH && !launched_p)
				open_move(0, 1'b0, 1'b1);
			else if (req.cmd == CMD_RESET && launched_p)
				open_move(0, 1'b0, 1'b0);
			else if (req.cmd == CMD_JOG && req.motor_sel < MOTOR_COUNT)
				open_move(int'(req.motor_sel), 1'b1, req.jog_forward);
		end
		lines.step_lines = (busy_p && pulse_p) ? (4'b0001 << active_p) : 4'b0000;
		lines.dir_lines = dirs_p;
		lines.moving = busy_p;
		lines.is_launched = launched_p;
		lines.move_done = done_p;
	endtask

	task automatic load_settings(input logic [SW-1:0] s1, s2, s3, s4, rl,
			input logic [DW-1:0] sl, fa);
		logic [SW-1:0]           vals [7];
		logic [CFG_IDX_BITS-1:0] idxs [7];
		vals = '{s1, s2, s3, s4, rl, SW'(sl), SW'(fa)};
		idxs = '{REG_STEPS_ONE, REG_STEPS_TWO, REG_STEPS_THREE, REG_STEPS_FOUR,
			REG_RAMP, REG_SLOW, REG_FAST};
		for (int k = 0; k < 7; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idxs[k];
			cfg_data <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		steps_p[0] = s1;
		steps_p[1] = s2;
		steps_p[2] = s3;
		steps_p[3] = s4;
		ramp_p = rl;
		slow_p = sl;
		fast_p = fa;
	endtask

	task automatic send(input item_t req, input bit typed, input result_t want);
		result_t lines;
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 30);
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 3);
		end
		burst_left--;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (item_stall);
		step_motion(req, lines);
		lines_due.push_back(typed ? want : lines);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (lines_due.size() != 0);
	endtask

	task automatic settle_block();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_out();
		item_t tick;
		tick = '0;
		tick.cmd = CMD_TICK;
		while (busy_p)
			send(tick, 1'b0, '0);
	endtask

	task automatic pick_request(output item_t req, output bit counts);
		int roll;
		roll = $urandom_range(0, 99);
		req.motor_sel = 2'($urandom_range(0, 3));
		req.jog_forward = 1'($urandom_range(0, 1));
		if (busy_p) begin
			if (roll < 88)
				req.cmd = CMD_TICK;
			else if (roll < 92)
				req.cmd = CMD_LAUNCH;
			else if (roll < 96)
				req.cmd = CMD_RESET;
			else
				req.cmd = CMD_JOG;
			counts = (req.cmd == CMD_TICK);
		end else begin
			if (roll < 45)
				req.cmd = launched_p ? CMD_RESET : CMD_LAUNCH;
			else if (roll < 80)
				req.cmd = CMD_JOG;
			else if (roll < 88)
				req.cmd = launched_p ? CMD_LAUNCH : CMD_RESET;
			else
				req.cmd = CMD_TICK;
			counts = (roll < 80);
		end
	endtask

	task automatic random_run(input int target, input int ph);
		item_t req;
		bit    counts;
		int    taken;
		taken = 0;
		while (taken < target) begin
			pick_request(req, counts);
			send(req, 1'b0, '0);
			if (counts) begin
				taken++;
				if (ph == 2 && taken == 60)
					hold_off_req = 1'b1;
				if (ph == 4 && taken == 90)
					wait_drained();
			end
		end
	endtask

	function automatic row_t plan_row(logic [1:0] c, logic [1:0] s, logic f, bit typed,
			result_t want, bit settle);
		row_t r;
		r.req.cmd = c;
		r.req.motor_sel = s;
		r.req.jog_forward = f;
		r.typed = typed;
		r.want = want;
		r.settle = settle;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (lines_due.size() == 0) begin
				note_error($sformatf("result %0d arrived with none outstanding", res_count));
			end else begin
				lines_want = lines_due.pop_front();
				if (res.step_lines !== lines_want.step_lines)
					note_error($sformatf("result %0d step_lines %b, want %b", res_count,
						res.step_lines, lines_want.step_lines));
				if (res.dir_lines !== lines_want.dir_lines)
					note_error($sformatf("result %0d dir_lines %b, want %b", res_count,
						res.dir_lines, lines_want.dir_lines));
				if (res.moving !== lines_want.moving)
					note_error($sformatf("result %0d moving %b, want %b", res_count,
						res.moving, lines_want.moving));
				if (res.is_launched !== lines_want.is_launched)
					note_error($sformatf("result %0d is_launched %b, want %b", res_count,
						res.is_launched, lines_want.is_launched));
				if (res.move_done !== lines_want.move_done)
					note_error($sformatf("result %0d move_done %b, want %b", res_count,
						res.move_done, lines_want.move_done));
			end
			res_count++;
		end
	end

	initial begin : receiver
		int mode;
		int mode_left;
		res_stall = 1'b0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				unique case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 7) == 0);
					2: res_stall <= 1'($urandom_range(0, 1));
					default: res_stall <= (mode_left % 4 == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		item_t req;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steps_p = '{SW'(RST_STEPS), SW'(RST_STEPS), SW'(RST_STEPS), SW'(RST_STEPS)};
		ramp_p = SW'(RST_RAMP);
		slow_p = DW'(RST_SLOW);
		fast_p = DW'(RST_FAST);
		{launched_p, busy_p, single_p, mdir_p, pulse_p, done_p} = '0;
		active_p = '0;
		step_idx_p = '0;
		hp_left_p = '0;
		hp_cur_p = '0;
		dirs_p = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_settings(2, 0, 1, 1, 1, 3, 1);
		plan.push_back(plan_row(CMD_TICK, 2'd0, 1'b0, 1'b1, '0, 1'b0));
		plan.push_back(plan_row(CMD_RESET, 2'd0, 1'b0, 1'b1, '0, 1'b0));
		plan.push_back(plan_row(CMD_JOG, 2'd1, 1'b1, 1'b1,
			result_t'({4'b0000, 4'b0000, 1'b0, 1'b0, 1'b1}), 1'b0));
		plan.push_back(plan_row(CMD_JOG, 2'd3, 1'b1, 1'b1,
			result_t'({4'b1000, 4'b1000, 1'b1, 1'b0, 1'b0}), 1'b0));
		plan.push_back(plan_row(CMD_LAUNCH, 2'd2, 1'b1, 1'b0, '0, 1'b0));
		plan.push_back(plan_row(CMD_JOG, 2'd0, 1'b0, 1'b0, '0, 1'b0));
		plan.push_back(plan_row(CMD_RESET, 2'd1, 1'b0, 1'b0, '0, 1'b1));
		plan.push_back(plan_row(CMD_JOG, 2'd3, 1'b0, 1'b0, '0, 1'b1));
		plan.push_back(plan_row(CMD_LAUNCH, 2'd0, 1'b0, 1'b0, '0, 1'b0));
		plan.push_back(plan_row(CMD_RESET, 2'd3, 1'b1, 1'b0, '0, 1'b1));
		plan.push_back(plan_row(CMD_LAUNCH, 2'd0, 1'b1, 1'b0, '0, 1'b0));
		plan.push_back(plan_row(CMD_JOG, 2'd2, 1'b0, 1'b0, '0, 1'b1));
		plan.push_back(plan_row(CMD_RESET, 2'd0, 1'b0, 1'b0, '0, 1'b1));
		plan.push_back(plan_row(CMD_TICK, 2'd3, 1'b1, 1'b0, '0, 1'b0));
		plan.push_back(plan_row(CMD_JOG, 2'd0, 1'b1, 1'b0, '0, 1'b1));
		plan.push_back(plan_row(CMD_JOG, 2'd2, 1'b1, 1'b0, '0, 1'b1));
		plan.push_back(plan_row(CMD_RESET, 2'd2, 1'b1, 1'b0, '0, 1'b0));
		foreach (plan[k]) begin
			send(plan[k].req, plan[k].typed, plan[k].want);
			if (plan[k].settle)
				run_out();
		end
		run_out();
		settle_block();

		load_settings(0, 0, 0, 0, 0, 0, 0);
		random_run(30, 0);

		for (int ph = 1; ph <= 6; ph++) begin
			run_out();
			settle_block();
			load_settings(SW'($urandom_range(0, 2 + ph)), SW'($urandom_range(0, 2 + ph)),
				SW'($urandom_range(0, 2 + ph)), SW'($urandom_range(0, 2 + ph)),
				SW'($urandom_range(0, 5)), DW'($urandom_range(0, 6)),
				DW'($urandom_range(0, 6)));
			random_run(120, ph);
		end

		// single step at full-scale half period, ramp longer than the move; hold its
		// high phase for a few ticks, then offer a jog while it is still busy
		run_out();
		settle_block();
		load_settings(1, 0, 0, {SW{1'b1}}, {SW{1'b1}}, {DW{1'b1}}, {DW{1'b1}});
		req = '0;
		req.cmd = CMD_JOG;
		req.jog_forward = 1'b1;
		send(req, 1'b0, '0);
		req.cmd = CMD_TICK;
		repeat (EDGE_TICKS)
			send(req, 1'b0, '0);
		req.cmd = CMD_JOG;
		req.motor_sel = 2'd1;
		req.jog_forward = 1'b0;
		send(req, 1'b0, '0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
